### rtl/aes_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AES package
// Shared constants, types and GF(2^8) helper functions for the AES core.
// ---------------------------------------------------------------------------
package aes_pkg;

    localparam int KEY_SCHEDULE_WORDS_DEF = 60;
    localparam int KEY_SIZE_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_KEY_SIZE = 3'd0,
        REG_DECRYPT  = 3'd1,
        REG_KEY_W0   = 3'd2,
        REG_KEY_W1   = 3'd3,
        REG_KEY_W2   = 3'd4,
        REG_KEY_W3   = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KS_128 = 2'd0,
        KS_192 = 2'd1,
        KS_256 = 2'd2
    } key_size_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_LOAD,
        ST_KEY_EXPAND,
        ST_ROUND_FETCH,
        ST_ROUND,
        ST_DONE
    } state_t;

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] p;
        logic [7:0] t;
        p = 8'h00;
        t = a;
        for (int i = 0; i < 4; i++) begin
            if (b[i]) p = p ^ t;
            t = xtime(t);
        end
        gmul = p;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        sbox = tbl[x];
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] y);
        logic [7:0] tbl [256];
        tbl = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        inv_sbox = tbl[y];
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        subst_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

### rtl/aes_round.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AES round unit
// One forward or inverse cipher round on a 128-bit state, shared over rounds.
// ---------------------------------------------------------------------------
module aes_round (
    input  logic [127:0] state_in,
    input  logic [127:0] key_in,
    input  logic         inv,
    input  logic         first,
    input  logic         last,
    output logic [127:0] state_out
);
    import aes_pkg::*;

    logic [7:0] s  [16];
    logic [7:0] t  [16];
    logic [7:0] u  [16];
    logic [7:0] k  [16];
    logic [7:0] m  [16];
    logic [7:0] o  [16];

    always_comb
    begin
        for (int i = 0; i < 16; i++) begin
            s[i] = state_in[127-8*i -: 8];
            k[i] = key_in[127-8*i -: 8];
        end
        // Byte substitution and row shift; the two commute.
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (inv)
                    t[r+4*((c+r)%4)] = inv_sbox(s[r+4*c]);
                else
                    t[r+4*c] = sbox(s[r+4*((c+r)%4)]);
            end
        end
        // Inverse rounds add the key before mixing.
        for (int i = 0; i < 16; i++)
            u[i] = inv ? (t[i] ^ k[i]) : t[i];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv)
                    m[4*c+r] = gmul(u[4*c+r], 4'd14) ^ gmul(u[4*c+(r+1)%4], 4'd11)
                             ^ gmul(u[4*c+(r+2)%4], 4'd13) ^ gmul(u[4*c+(r+3)%4], 4'd9);
                else
                    m[4*c+r] = gmul(u[4*c+r], 4'd2) ^ gmul(u[4*c+(r+1)%4], 4'd3)
                             ^ u[4*c+(r+2)%4] ^ u[4*c+(r+3)%4];
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (first)
                o[i] = s[i] ^ k[i];
            else if (last)
                o[i] = t[i] ^ k[i];
            else if (inv)
                o[i] = m[i];
            else
                o[i] = m[i] ^ k[i];
        end
        for (int i = 0; i < 16; i++)
            state_out[127-8*i -: 8] = o[i];
    end

endmodule

### rtl/aes_block_cipher_core.sv
`timescale 1ns / 1ps
// After a request is accepted (Nr = 10, 12, 14), ST_ROUND_FETCH reads the first round
// key, then ST_ROUND makes Nr + 1 passes of the shared round unit and ST_DONE shows the result.
// A new request is taken only after the result has been taken and the core is idle again.
// The first request after a register write is preceded by key expansion into 4*(Nr+1) words,
// one schedule word per cycle. Reset (rst_n, asynchronous) clears control state and
// the configuration registers; the schedule is marked invalid and rebuilt on demand.
// ---------------------------------------------------------------------------
// AES block cipher core
// FIPS-197 forward/inverse cipher with 128, 192 or 256-bit keys, iterative.
// ---------------------------------------------------------------------------
module aes_block_cipher_core #(
    parameter int KEY_SCHEDULE_WORDS = aes_pkg::KEY_SCHEDULE_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [aes_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [aes_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [63:0]                   block_high,
    input  logic [63:0]                   block_low,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [63:0]                   result_high,
    output logic [63:0]                   result_low
);
    import aes_pkg::*;

    // The schedule is stored as whole round keys, one column per bank, so a
    // full round key comes out of the store in a single read.
    localparam int ROUND_KEYS = KEY_SCHEDULE_WORDS / 4;
    localparam int RA = $clog2(ROUND_KEYS);

    // Configuration registers.
    logic [KEY_SIZE_W-1:0] key_size_reg;
    logic        decrypt_reg;
    logic [63:0] key_word_reg [4];
    logic        sched_valid_reg;

    // Sequencer state.
    state_t      state_reg, state_next;
    logic [5:0]  widx_reg, widx_next;     // schedule word index during expansion
    logic [3:0]  rnd_reg, rnd_next;       // round counter during cipher
    logic [2:0]  kpos_reg, kpos_next;     // word index modulo Nk during expansion
    logic [7:0]  rcon_reg, rcon_next;
    logic [3:0]  nk_reg;
    logic [3:0]  nr_reg;
    logic [127:0] data_reg, data_next;
    logic [127:0] rkey_reg;               // registered read data of the key store

    // The last eight schedule words, newest first; expansion reads from here.
    logic [31:0] win_reg [8];

    // Key store: four column banks, one write port, one registered read port.
    logic [31:0]   key_mem [4][ROUND_KEYS];
    logic          mem_we;
    logic [31:0]   mem_wdata;
    logic [RA-1:0] mem_raddr;

    // Nk choice with the fallback when the store is too small.
    logic [3:0] nk_sel;
    always_comb
    begin
        case (key_size_reg)
            KS_192:  nk_sel = 4'd6;
            KS_256:  nk_sel = 4'd8;
            default: nk_sel = 4'd4;
        endcase
        if (nk_sel == 4'd8 && KEY_SCHEDULE_WORDS < 60) nk_sel = 4'd6;
        if (nk_sel == 4'd6 && KEY_SCHEDULE_WORDS < 52) nk_sel = 4'd4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= '0;
            decrypt_reg <= 1'b0;
            for (int i = 0; i < 4; i++) key_word_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_KEY_SIZE: key_size_reg <= cfg_wdata[1:0];
                REG_DECRYPT:  decrypt_reg <= cfg_wdata[0];
                REG_KEY_W0:   key_word_reg[0] <= cfg_wdata;
                REG_KEY_W1:   key_word_reg[1] <= cfg_wdata;
                REG_KEY_W2:   key_word_reg[2] <= cfg_wdata;
                REG_KEY_W3:   key_word_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Expansion: word i is word i-Nk of the window XORed with a transform
    // of word i-1. The transform depends on i modulo Nk, kept in kpos_reg.
    logic [31:0] kw_init;
    logic [31:0] prev_word;
    logic [31:0] back_word;
    logic [31:0] t_word;
    logic [31:0] exp_word;
    logic [5:0]  total_words;

    assign total_words = {nk_reg + 4'd7, 2'b00};
    assign kw_init = widx_reg[0] ? key_word_reg[widx_reg[2:1]][31:0]
                                 : key_word_reg[widx_reg[2:1]][63:32];
    assign prev_word = win_reg[0];

    always_comb
    begin
        case (nk_reg)
            4'd6:    back_word = win_reg[5];
            4'd8:    back_word = win_reg[7];
            default: back_word = win_reg[3];
        endcase
        t_word = prev_word;
        if (kpos_reg == 3'd0)
            t_word = subst_word({prev_word[23:0], prev_word[31:24]}) ^ {rcon_reg, 24'h0};
        else if (nk_reg == 4'd8 && kpos_reg == 3'd4)
            t_word = subst_word(prev_word);
        exp_word = back_word ^ t_word;
    end

    // Round unit: the first pass only adds a key, the last one skips mixing.
    logic [127:0] round_out;
    logic first_rnd, last_rnd;
    assign first_rnd = (rnd_reg == 4'd0);
    assign last_rnd  = (rnd_reg == nr_reg);

    aes_round u_round (
        .state_in  (data_reg),
        .key_in    (rkey_reg),
        .inv       (decrypt_reg),
        .first     (first_rnd),
        .last      (last_rnd),
        .state_out (round_out)
    );

    // The key for the coming round is read in the cycle before it is used; the inverse
    // cipher walks the schedule backwards.
    logic [3:0] key_round;
    assign key_round = decrypt_reg ? (nr_reg - rnd_next) : rnd_next;
    assign mem_raddr = key_round[RA-1:0];

    always_comb
    begin
        state_next = state_reg;
        widx_next  = widx_reg;
        rnd_next   = rnd_reg;
        rcon_next  = rcon_reg;
        kpos_next  = kpos_reg;
        data_next  = data_reg;
        mem_we     = 1'b0;
        mem_wdata  = kw_init;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    data_next = {block_high, block_low};
                    widx_next = '0;
                    rcon_next = 8'h01;
                    kpos_next = '0;
                    rnd_next  = '0;
                    state_next = sched_valid_reg ? ST_ROUND_FETCH : ST_KEY_LOAD;
                end
            end
            ST_KEY_LOAD:
            begin
                // Copy the raw key words into the store and the window.
                mem_we    = 1'b1;
                mem_wdata = kw_init;
                widx_next = widx_reg + 6'd1;
                if (widx_reg + 6'd1 == {2'b00, nk_reg})
                    state_next = ST_KEY_EXPAND;
            end
            ST_KEY_EXPAND:
            begin
                mem_we    = 1'b1;
                mem_wdata = exp_word;
                widx_next = widx_reg + 6'd1;
                if (kpos_reg == 3'd0) rcon_next = xtime(rcon_reg);
                kpos_next = (kpos_reg == 3'(nk_reg - 4'd1)) ? 3'd0 : kpos_reg + 3'd1;
                if (widx_reg + 6'd1 == total_words)
                    state_next = ST_ROUND_FETCH;
            end
            ST_ROUND_FETCH:
            begin
                // The key for the first pass is being read this cycle.
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                data_next = round_out;
                if (last_rnd)
                    state_next = ST_DONE;
                else
                    rnd_next = rnd_reg + 4'd1;
            end
            ST_DONE:
            begin
                if (!out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sched_valid_reg <= 1'b0;
            widx_reg <= '0;
            rnd_reg <= '0;
            rcon_reg <= 8'h01;
            kpos_reg <= '0;
            nk_reg <= 4'd4;
            nr_reg <= 4'd10;
        end
        else
        begin
            state_reg <= state_next;
            widx_reg <= widx_next;
            rnd_reg <= rnd_next;
            rcon_reg <= rcon_next;
            kpos_reg <= kpos_next;
            if (state_reg == ST_IDLE && in_valid)
            begin
                nk_reg <= nk_sel;
                nr_reg <= nk_sel + 4'd6;
            end
            if (cfg_we && (cfg_addr <= REG_KEY_W3))
                sched_valid_reg <= 1'b0;
            else if (state_reg == ST_KEY_EXPAND && state_next == ST_ROUND_FETCH)
                sched_valid_reg <= 1'b1;
        end
    end

    // Key store write and read, and the expansion window.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[widx_reg[1:0]][widx_reg[2 +: RA]] <= mem_wdata;
            win_reg[0] <= mem_wdata;
            for (int j = 1; j < 8; j++)
                win_reg[j] <= win_reg[j-1];
        end
        for (int c = 0; c < 4; c++)
            rkey_reg[127-32*c -: 32] <= key_mem[c][mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_DONE);
    assign result_high = data_reg[127:64];
    assign result_low  = data_reg[63:0];

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result shown while accepting a new request");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && last_rnd) |=> out_valid)
        else $error("final round did not present a result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEY_EXPAND && state_next == ST_ROUND_FETCH) |=> sched_valid_reg)
        else $error("schedule not marked valid after expansion");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result_high)
                                      && $stable(result_low)))
        else $error("stalled result changed or was dropped");

endmodule
